// ----- rtl/core/rounded_rect_fill_engine_top_macros.svh -----
// Assertion macros for the rounded rectangle fill engine.
// Expect clk_i and rst_ni in the scope of each use.
`ifndef ROUNDED_RECT_FILL_ENGINE_TOP_MACROS_SVH
`define ROUNDED_RECT_FILL_ENGINE_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RRF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rrf assertion failed");

// Check that an effect follows in the cycle after its cause.
`define RRF_ASSERT_NEXT(name, cause, effect) \
  `RRF_ASSERT(name, (cause) |=> (effect))

`endif

// ----- rtl/core/rrf_pkg.sv -----
// Shared types and constants for the rounded rectangle fill engine.
// No dependencies.
package rrf_pkg;

  localparam int unsigned MAX_SURFACE_WIDTH  = 256;
  localparam int unsigned MAX_SURFACE_HEIGHT = 256;

  localparam int unsigned SURF_W     = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned AREA_W     = 2 * SURF_W;

  localparam logic [SURF_W-1:0]  SURF_RESET = 9'd256;
  localparam logic [COLOR_W-1:0] WHITE      = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    ACT_DRAW  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SURFACE_WIDTH  = 1'b0,
    REG_SURFACE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        [1:0]  action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [11:0] rect_width;
    logic        [11:0] rect_height;
    logic        [11:0] corner_radius;
    logic        [31:0] color_in;
  } cmd_t;

endpackage

// ----- rtl/core/rrf_if.sv -----
// Handshake channels of the fill engine: command, result and register write.
// Depends on rrf_pkg.
interface rrf_cmd_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic        [11:0] rect_width;
  logic        [11:0] rect_height;
  logic        [11:0] corner_radius;
  logic        [31:0] color_in;

  modport source (output valid, action, pos_x, pos_y, rect_width, rect_height,
                  corner_radius, color_in, input ready);
  modport sink   (input valid, action, pos_x, pos_y, rect_width, rect_height,
                  corner_radius, color_in, output ready);
endinterface

interface rrf_res_if;
  logic                          valid;
  logic                          ready;
  logic [rrf_pkg::COLOR_W-1:0]   pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink   (input valid, pixel_color, output ready);
endinterface

interface rrf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rrf_pkg::CFG_IDX_W-1:0]   index;
  logic [rrf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/rounded_rect_fill_engine_top.sv -----
// Top level of the rounded rectangle fill engine: register file, sequencer
// and framebuffer. Depends on rrf_pkg, rrf_if, rrf_store and rrf_raster.
//
//   channel  dir  handshake        carries
//   cmd_i    in   valid / ready    action, position, size, radius, color
//   res_o    out  valid / ready    pixel_color, one per command
//   cfg_i    in   valid / ready    register index, write data
//
// Draw: scans the clipped rectangle area, one pixel a cycle, writing pixels
// inside the rounded shape through the framebuffer write port. Clear: white
// over width * height. Read: registered memory read. One command at a time.
// Reset sets both surface registers to 256; framebuffer contents are undefined.
// A stalled result holds in its register; the next command is taken meanwhile.
`include "rounded_rect_fill_engine_top_macros.svh"

module rounded_rect_fill_engine_top #(
  parameter int unsigned MAX_SURFACE_WIDTH  = rrf_pkg::MAX_SURFACE_WIDTH,
  parameter int unsigned MAX_SURFACE_HEIGHT = rrf_pkg::MAX_SURFACE_HEIGHT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rrf_cmd_if.sink   cmd_i,
  rrf_res_if.source res_o,
  rrf_cfg_if.sink   cfg_i
);

  localparam int unsigned DEPTH = MAX_SURFACE_WIDTH * MAX_SURFACE_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = rrf_pkg::SURF_W;

  logic [SW-1:0]               width_q, height_q, eff_w, eff_h;
  rrf_pkg::cmd_t               cmd;
  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [rrf_pkg::COLOR_W-1:0] wr_data, rd_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rrf_pkg::SURF_RESET;
      height_q <= rrf_pkg::SURF_RESET;
    end else if (cfg_i.valid) begin
      case (rrf_pkg::cfg_reg_e'(cfg_i.index))
        rrf_pkg::REG_SURFACE_WIDTH:  width_q  <= cfg_i.data;
        rrf_pkg::REG_SURFACE_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign eff_w = ({4'd0, width_q} > 13'(MAX_SURFACE_WIDTH)) ?
                 SW'(MAX_SURFACE_WIDTH) : width_q;
  assign eff_h = ({4'd0, height_q} > 13'(MAX_SURFACE_HEIGHT)) ?
                 SW'(MAX_SURFACE_HEIGHT) : height_q;

  assign cmd.action        = cmd_i.action;
  assign cmd.pos_x         = cmd_i.pos_x;
  assign cmd.pos_y         = cmd_i.pos_y;
  assign cmd.rect_width    = cmd_i.rect_width;
  assign cmd.rect_height   = cmd_i.rect_height;
  assign cmd.corner_radius = cmd_i.corner_radius;
  assign cmd.color_in      = cmd_i.color_in;

  rrf_raster #(
    .AW (AW)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .cmd_i       (cmd),
    .eff_w_i     (eff_w),
    .eff_h_i     (eff_h),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_color_o (res_o.pixel_color),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  rrf_store #(
    .AW (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  `RRF_ASSERT(a_no_rw_overlap, !(wr_en && rd_en))
  `RRF_ASSERT(a_no_write_when_idle, wr_en |-> !cmd_i.ready)
  `RRF_ASSERT_NEXT(a_one_cmd_at_a_time, cmd_i.valid && cmd_i.ready, !cmd_i.ready)

endmodule

// ----- rtl/core/rrf_store.sv -----
// Framebuffer memory: one write port, one read port, registered read data.
// Depends on rrf_pkg.
module rrf_store #(
  parameter int unsigned AW = 16
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [rrf_pkg::COLOR_W-1:0]  wr_data_i,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [rrf_pkg::COLOR_W-1:0]  rd_data_o
);

  logic [rrf_pkg::COLOR_W-1:0] mem [2**AW];
  logic [rrf_pkg::COLOR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/rrf_raster.sv -----
// Command sequencer: clips, scans pixels through a pipelined corner test,
// sweeps clears and issues reads against the framebuffer. Depends on rrf_pkg.
module rrf_raster #(
  parameter int unsigned AW = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  rrf_pkg::cmd_t                     cmd_i,
  input  logic [rrf_pkg::SURF_W-1:0]        eff_w_i,
  input  logic [rrf_pkg::SURF_W-1:0]        eff_h_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic [rrf_pkg::COLOR_W-1:0]       res_color_o,
  output logic                              wr_en_o,
  output logic [AW-1:0]                     wr_addr_o,
  output logic [rrf_pkg::COLOR_W-1:0]       wr_data_o,
  output logic                              rd_en_o,
  output logic [AW-1:0]                     rd_addr_o,
  input  logic [rrf_pkg::COLOR_W-1:0]       rd_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_SQUARE, ST_SCAN, ST_DRAIN,
    ST_CLRSET, ST_CLEAR, ST_RDCHK, ST_RDMEM, ST_RDWAIT, ST_DONE
  } state_e;

  localparam int unsigned AREA_W = rrf_pkg::AREA_W;

  state_e                        state_q;
  logic                          p1_vld_q, p2_vld_q;
  logic                          res_valid_q;
  logic [rrf_pkg::COLOR_W-1:0]   res_color_q, result_q;
  logic [AREA_W-1:0]             clr_q, area_q;

  rrf_pkg::cmd_t                 cmd_q;
  logic signed [17:0]            c0_q, c1_q, r0_q, r1_q;
  logic [10:0]                   b_q;
  logic [21:0]                   r2_q;
  logic [11:0]                   wb_q, hb_q, col_q, row_q, cstart_q, cend_q, rend_q;
  logic [10:0]                   dx_q, dy_q;
  logic [8:0]                    px_q, py_q;
  logic [21:0]                   dx2_q, dy2_q;
  logic                          trivial_q;
  logic [AREA_W-1:0]             addr_q;

  logic signed [17:0] xs, ys, sw, sh, wd_s, ht_s, c1a, r1a;
  logic [10:0]        half_w, half_h, bw, b_d;
  logic [10:0]        dx_d, dy_d;
  logic [11:0]        dx_t, dy_t;
  logic [16:0]        px_t, py_t;
  logic               last_col, last_row, pix_wr, in_bounds;
  logic [22:0]        dsq_sum;

  always_comb begin
    xs     = 18'(cmd_q.pos_x);
    ys     = 18'(cmd_q.pos_y);
    sw     = $signed({9'd0, eff_w_i});
    sh     = $signed({9'd0, eff_h_i});
    wd_s   = $signed({6'd0, cmd_q.rect_width});
    ht_s   = $signed({6'd0, cmd_q.rect_height});
    c1a    = sw - xs;
    r1a    = sh - ys;
    half_w = cmd_q.rect_width[11:1];
    half_h = cmd_q.rect_height[11:1];
    bw     = (cmd_q.corner_radius > {1'b0, half_w}) ? half_w : cmd_q.corner_radius[10:0];
    b_d    = (bw > half_h) ? half_h : bw;
    in_bounds = (xs >= 18'sd0) && (ys >= 18'sd0) && (xs < sw) && (ys < sh);
  end

  always_comb begin
    dx_t = 12'd0;
    dy_t = 12'd0;
    if (b_q != 11'd0) begin
      if (col_q < {1'b0, b_q}) begin
        dx_t = {1'b0, b_q} - col_q;
      end else if (col_q >= wb_q) begin
        dx_t = col_q - wb_q + 12'd1;
      end
      if (row_q < {1'b0, b_q}) begin
        dy_t = {1'b0, b_q} - row_q;
      end else if (row_q >= hb_q) begin
        dy_t = row_q - hb_q + 12'd1;
      end
    end
    dx_d     = dx_t[10:0];
    dy_d     = dy_t[10:0];
    px_t     = 17'(cmd_q.pos_x) + {5'd0, col_q};
    py_t     = 17'(cmd_q.pos_y) + {5'd0, row_q};
    last_col = (12'(col_q + 12'd1) == cend_q);
    last_row = (12'(row_q + 12'd1) == rend_q);
    dsq_sum  = {1'b0, dx2_q} + {1'b0, dy2_q};
    pix_wr   = p2_vld_q && (trivial_q || (dsq_sum <= {1'b0, r2_q}));
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_color_o = res_color_q;
  assign wr_en_o     = (state_q == ST_CLEAR) || pix_wr;
  assign wr_addr_o   = (state_q == ST_CLEAR) ? AW'(clr_q) : AW'(addr_q);
  assign wr_data_o   = (state_q == ST_CLEAR) ? rrf_pkg::WHITE : cmd_q.color_in[31:8];
  assign rd_en_o     = (state_q == ST_RDMEM);
  assign rd_addr_o   = AW'(addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
      res_color_q <= '0;
      result_q    <= '0;
      clr_q       <= '0;
      area_q      <= '0;
    end else begin
      p2_vld_q <= p1_vld_q;
      p1_vld_q <= (state_q == ST_SCAN);
      if (res_valid_q && res_ready_i && state_q != ST_DONE) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            result_q <= '0;
            case (cmd_i.action)
              rrf_pkg::ACT_DRAW:  state_q <= ST_SETUP;
              rrf_pkg::ACT_CLEAR: state_q <= ST_CLRSET;
              rrf_pkg::ACT_READ:  state_q <= ST_RDCHK;
              default:            state_q <= ST_DONE;
            endcase
          end
        end
        ST_SETUP:  state_q <= ST_SQUARE;
        ST_SQUARE: begin
          if (cmd_q.rect_width == 12'd0 || cmd_q.rect_height == 12'd0 ||
              c0_q >= c1_q || r0_q >= r1_q) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last_col && last_row) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!p1_vld_q && !p2_vld_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_CLRSET: begin
          area_q <= {9'd0, eff_w_i} * {9'd0, eff_h_i};
          clr_q  <= '0;
          if (eff_w_i == '0 || eff_h_i == '0) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          clr_q <= AREA_W'(clr_q + 1'b1);
          if (AREA_W'(clr_q + 1'b1) == area_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_RDCHK: state_q <= in_bounds ? ST_RDMEM : ST_DONE;
        ST_RDMEM: state_q <= ST_RDWAIT;
        ST_RDWAIT: begin
          result_q <= rd_data_i;
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid_q || res_ready_i) begin
            res_valid_q <= 1'b1;
            res_color_q <= result_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_SETUP) begin
      c0_q <= (xs < 18'sd0) ? -xs : 18'sd0;
      c1_q <= (c1a < wd_s) ? c1a : wd_s;
      r0_q <= (ys < 18'sd0) ? -ys : 18'sd0;
      r1_q <= (r1a < ht_s) ? r1a : ht_s;
      b_q  <= b_d;
    end
    if (state_q == ST_SQUARE) begin
      r2_q     <= {11'd0, b_q} * {11'd0, b_q};
      wb_q     <= cmd_q.rect_width - {1'b0, b_q};
      hb_q     <= cmd_q.rect_height - {1'b0, b_q};
      cstart_q <= c0_q[11:0];
      col_q    <= c0_q[11:0];
      row_q    <= r0_q[11:0];
      cend_q   <= c1_q[11:0];
      rend_q   <= r1_q[11:0];
    end
    if (state_q == ST_SCAN) begin
      if (last_col) begin
        col_q <= cstart_q;
        row_q <= 12'(row_q + 12'd1);
      end else begin
        col_q <= 12'(col_q + 12'd1);
      end
      dx_q <= dx_d;
      dy_q <= dy_d;
      px_q <= px_t[8:0];
      py_q <= py_t[8:0];
    end
    dx2_q     <= {11'd0, dx_q} * {11'd0, dx_q};
    dy2_q     <= {11'd0, dy_q} * {11'd0, dy_q};
    trivial_q <= (dx_q == 11'd0) || (dy_q == 11'd0);
    if (state_q == ST_RDCHK) begin
      addr_q <= {9'd0, ys[8:0]} * {9'd0, eff_w_i} + {9'd0, xs[8:0]};
    end else begin
      addr_q <= {9'd0, py_q} * {9'd0, eff_w_i} + {9'd0, px_q};
    end
  end

endmodule
